@@ rtl/core/assert_macros.svh @@
// Assertion helper macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion disabled while reset is high
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lfmm_pkg.sv @@
// Shared types and constants for the labeled feature memory matcher.
// No dependencies.
package lfmm_pkg;

  localparam int ACC_W = 40;
  localparam int AGE_W = 16;
  localparam int FV_W  = 16;

  localparam logic [1:0] CMD_SCORE  = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCORE,
    ST_UPDATE,
    ST_TICK
  } state_t;

  // Per-class contents of one ring cell
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [AGE_W-1:0]        age;
  } cell_data_t;

  // Ring control from the sequencer
  typedef struct packed {
    logic shift;
    logic clear;
  } ring_ctrl_t;

endpackage

@@ rtl/core/lfmm_cell.sv @@
// One ring cell: accumulator and age of one class, passed on when shifting.
// Depends on lfmm_pkg.
module lfmm_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lfmm_pkg::ring_ctrl_t ctrl,
  input  lfmm_pkg::cell_data_t data_in,
  output lfmm_pkg::cell_data_t data_out
);

  lfmm_pkg::cell_data_t data;

  // Load from neighbor on shift
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      data <= '0;
    end else if (ctrl.shift) begin
      data <= data_in;
    end
  end

  assign data_out = data;

endmodule

@@ rtl/core/lfmm_bank.sv @@
// Feature bank memory: one write port, one registered read port.
// Depends on nothing.
module lfmm_bank #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/labeled_feature_memory_matcher_unit.sv @@
// Labeled feature memory matcher top level.
// Requests are taken one at a time: start is accepted only while idle, and busy stays
//   high for the whole of a score element, an update or a tick.
// Results of a last score element stream out one per cycle, class 0 first, no stall.
// Reset: synchronous, then busy for a clearing pass that writes zero to every bank address.
module labeled_feature_memory_matcher_unit #(
  parameter int CLASS_COUNT = 64,
  parameter int FEAT_DIM    = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               momentum_we,
  input  logic [15:0]        momentum_wdata,
  input  logic [1:0]         command,
  input  logic signed [15:0] feature_value,
  input  logic [7:0]         element_index,
  input  logic signed [15:0] label,
  input  logic               last_element,
  output logic               result_valid,
  output logic signed [39:0] score,
  output logic [5:0]         class_number,
  output logic signed [6:0]  checked_label,
  output logic               last_score
);

  localparam int CW = $clog2(CLASS_COUNT);
  localparam int IW = (FEAT_DIM > 1) ? $clog2(FEAT_DIM) : 1;
  localparam int AW = CW + IW;
  localparam logic [CW:0] NC       = (CW+1)'(CLASS_COUNT);
  localparam logic [CW:0] UPD_LAST = (CLASS_COUNT > 3) ? (CW+1)'(CLASS_COUNT - 1) : (CW+1)'(2);
  localparam logic [8:0]  FD       = 9'(FEAT_DIM);

  lfmm_pkg::state_t state, state_next;

  logic [15:0]        momentum;
  logic signed [15:0] x_q;
  logic [7:0]         idx_q;
  logic [15:0]        lab_q;
  logic               last_q;
  logic [CW:0]        cnt;
  logic [AW-1:0]      clr_addr;
  logic               v1, v2;
  logic [CW-1:0]      oc;
  logic signed [31:0] prod;
  logic [31:0]        pm;
  logic [32:0]        px;

  logic               accept, in_lab_ok, lab_ok, idx_ok;
  logic               bank_we;
  logic [AW-1:0]      bank_waddr, bank_raddr;
  logic [15:0]        bank_wdata, bank_rdata;
  logic [33:0]        blend;
  logic signed [40:0] sum;
  logic signed [39:0] sat;

  lfmm_pkg::ring_ctrl_t ring_ctrl;
  lfmm_pkg::cell_data_t ring_in  [CLASS_COUNT];
  lfmm_pkg::cell_data_t ring_out [CLASS_COUNT];
  lfmm_pkg::cell_data_t tail;

  assign accept    = start && !busy;
  assign in_lab_ok = !label[15] && (label < 16'(CLASS_COUNT));
  assign lab_ok    = !lab_q[15] && (lab_q < 16'(CLASS_COUNT));
  assign idx_ok    = 9'(idx_q) < FD;

  // Momentum register
  always_ff @(posedge clk) begin
    if (rst) begin
      momentum <= 16'd32768;
    end else if (momentum_we) begin
      momentum <= momentum_wdata;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfmm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfmm_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = lfmm_pkg::ST_IDLE;
      end
      lfmm_pkg::ST_IDLE: begin
        if (start) begin
          if (command == lfmm_pkg::CMD_SCORE) state_next = lfmm_pkg::ST_SCORE;
          else if (command == lfmm_pkg::CMD_UPDATE && in_lab_ok)
            state_next = lfmm_pkg::ST_UPDATE;
          else if (command == lfmm_pkg::CMD_TICK) state_next = lfmm_pkg::ST_TICK;
        end
      end
      lfmm_pkg::ST_SCORE: begin
        if (v2 && oc == CW'(CLASS_COUNT - 1)) state_next = lfmm_pkg::ST_IDLE;
      end
      lfmm_pkg::ST_UPDATE: begin
        if (cnt == UPD_LAST) state_next = lfmm_pkg::ST_IDLE;
      end
      lfmm_pkg::ST_TICK: begin
        if (cnt == NC - 1'b1) state_next = lfmm_pkg::ST_IDLE;
      end
      default: state_next = lfmm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy            = 1'b1;
    ring_ctrl.shift = 1'b0;
    ring_ctrl.clear = 1'b0;
    bank_we         = 1'b0;
    bank_waddr      = {lab_q[CW-1:0], idx_q[IW-1:0]};
    bank_wdata      = blend[31:16] ^ 16'h8000;
    bank_raddr      = {lab_q[CW-1:0], idx_q[IW-1:0]};
    unique case (state)
      lfmm_pkg::ST_CLEAR: begin
        ring_ctrl.clear = 1'b1;
        bank_we         = 1'b1;
        bank_waddr      = clr_addr;
        bank_wdata      = '0;
      end
      lfmm_pkg::ST_IDLE: busy = 1'b0;
      lfmm_pkg::ST_SCORE: begin
        ring_ctrl.shift = v2;
        bank_raddr      = {cnt[CW-1:0], idx_q[IW-1:0]};
      end
      lfmm_pkg::ST_UPDATE: begin
        ring_ctrl.shift = cnt < NC;
        bank_we         = (cnt == (CW+1)'(2)) && idx_ok;
      end
      lfmm_pkg::ST_TICK: ring_ctrl.shift = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Request capture, counters and the score pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      clr_addr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      oc       <= '0;
    end else begin
      if (state == lfmm_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (accept) begin
        cnt <= '0;
        oc  <= '0;
      end else if (state == lfmm_pkg::ST_SCORE) begin
        if (cnt < NC) cnt <= cnt + 1'b1;
        if (v2) oc <= oc + 1'b1;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
      end
      v1 <= (state == lfmm_pkg::ST_SCORE) && (cnt < NC);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q    <= feature_value;
      idx_q  <= element_index;
      lab_q  <= label;
      last_q <= last_element;
    end
    prod <= idx_ok ? $signed(bank_rdata) * x_q : 32'sd0;
    pm   <= momentum * (bank_rdata ^ 16'h8000);
    px   <= (17'h10000 - 17'(momentum)) * 16'(x_q ^ 16'sh8000);
  end

  assign blend = 34'(pm) + 34'(px) + 34'd32768;

  // Saturating accumulate at the ring head
  assign sum = 41'(ring_out[0].acc) + 41'(prod);
  always_comb begin
    if (sum[40] != sum[39]) sat = sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    else sat = sum[39:0];
  end

  // Value that enters the ring tail
  always_comb begin
    tail = ring_out[0];
    unique case (state)
      lfmm_pkg::ST_SCORE:  tail.acc = last_q ? '0 : sat;
      lfmm_pkg::ST_UPDATE: if (16'(cnt) == lab_q) tail.age = '0;
      lfmm_pkg::ST_TICK:   if (ring_out[0].age != '1) tail.age = ring_out[0].age + 1'b1;
      default: tail = ring_out[0];
    endcase
  end

  // Class ring
  for (genvar i = 0; i < CLASS_COUNT; i++) begin : g_ring
    if (i == CLASS_COUNT - 1) begin : g_tail
      assign ring_in[i] = tail;
    end else begin : g_mid
      assign ring_in[i] = ring_out[i+1];
    end
    lfmm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ring_ctrl),
      .data_in  (ring_in[i]),
      .data_out (ring_out[i])
    );
  end

  lfmm_bank #(.AW(AW)) u_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .raddr (bank_raddr),
    .rdata (bank_rdata)
  );

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == lfmm_pkg::ST_SCORE) && v2 && last_q;
    end
  end

  always_ff @(posedge clk) begin
    score         <= sat;
    class_number  <= 6'(oc);
    checked_label <= lab_ok ? lab_q[6:0] : 7'h7F;
    last_score    <= oc == CW'(CLASS_COUNT - 1);
  end

endmodule

@@ rtl/core/lfmm_checker.sv @@
// Port-level checks on the matcher's busy after reset and its result stream, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lfmm_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       result_valid,
  input logic [5:0] class_number,
  input logic       last_score
);

  `CHK_ASSERT_ALWAYS(a_busy_rst, rst |=> busy, "not busy after reset")
  `CHK_ASSERT(a_run_first, $rose(result_valid) |-> class_number == 6'd0, "run not at class 0")
  `CHK_ASSERT(a_run_cont, result_valid && !last_score |=> result_valid, "gap in score run")
  `CHK_ASSERT(a_run_step, result_valid && !last_score |=> class_number == 6'($past(class_number) + 6'd1), "class order")
  `CHK_ASSERT(a_run_end, result_valid && last_score |=> !result_valid, "result after last")

endmodule

bind labeled_feature_memory_matcher_unit lfmm_checker u_chk (.*);
